/* rtl/core/mbs_pkg.sv */
// Shared constants and helper functions for the maze backtracker step block.
package mbs_pkg;

  // Default grid limits
  localparam int MAX_COLUMNS_DEF = 16;
  localparam int MAX_ROWS_DEF    = 8;

  // Register reset values
  localparam logic [4:0] GRID_COLUMNS_RST = 5'd16;
  localparam logic [3:0] GRID_ROWS_RST    = 4'd6;

  // Register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // Request opcodes
  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Walk directions, also the wall bit positions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [3:0] ALL_WALLS = 4'hF;

  // Remainder by three: 4 is 1 mod 3, so sum the base-4 digits and fold.
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    u = 3'(t[1:0]) + 3'(t[2]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

  // Position of the n-th set bit of a four-bit mask, lowest first.
  function automatic logic [1:0] nth_set(input logic [3:0] mask, input logic [1:0] n);
    logic [2:0] seen;
    logic [1:0] res;
    logic       found;
    seen  = '0;
    res   = '0;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i] && !found) begin
        if (seen == {1'b0, n}) begin
          res   = 2'(i);
          found = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
    return res;
  endfunction

endpackage

/* rtl/core/maze_backtracker_step.sv */
// Recursive backtracker maze generator: one walk step, restart or wall read per request.
//
// Requests enter on req_valid/req_stall and carry opcode, cell_index and
// random_value; one result leaves per request on res_valid/res_stall.
// Configuration (grid_columns, grid_rows) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block
// is idle, as the block itself does not enforce this.
// Visited bits and walls share one cell memory with two registered read
// ports and one write port; the backtrack stack is a second memory.
// A step reads the walker's cell and its four neighbors over the two
// read ports, then picks a neighbor and loads the result. After a
// backtrack or a configuration write a bit-serial divider rebuilds the
// walker's row and column first. A read fetches one cell's walls; a
// restart sweeps the cell memory.
// After reset a clearing pass sweeps the cell memory, one entry a cycle,
// with req_stall high; configuration writes are taken during it.
// Only one request is in flight; the next one is accepted once its result
// sits in the output register. A stalled result holds; the block waits
// for it to drain before loading the next one.
module maze_backtracker_step #(
  parameter int MAX_COLUMNS = mbs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = mbs_pkg::MAX_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  // request channel
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] opcode,
  input  logic [6:0] cell_index,
  input  logic [15:0] random_value,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic [6:0] current_cell,
  output logic       carved,
  output logic [1:0] carve_direction,
  output logic       backtracked,
  output logic       finished,
  output logic [7:0] stack_depth,
  output logic [3:0] cell_walls
);
  import mbs_pkg::*;

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int SP_W       = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ROW_W      = CELL_W;
  localparam int UC_W       = $clog2(MAX_COLUMNS + 1);
  localparam int UR_W       = $clog2(MAX_ROWS + 1);
  localparam int TOT_W      = UC_W + UR_W;
  localparam int CNT_W      = $clog2(CELL_W + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_RD0, S_RD1, S_RD2, S_PICK, S_RDC, S_RDW, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [4:0] grid_columns;
  logic [3:0] grid_rows;

  // walker and stack state
  logic [CELL_W-1:0] walker;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              coord_valid;
  logic [SP_W-1:0]   sp;
  logic [SP_W-1:0]   sp_dec;

  // request fields and per-request flags
  logic [6:0]  cell_q;
  logic [15:0] rnd_q;
  logic        read_ok;
  logic        clr_item;
  logic        carved_q;
  logic [1:0]  dir_q;
  logic        back_q;
  logic        done_q;
  logic [3:0]  walls_q;

  // divider
  logic [UC_W-1:0]   div_rem;
  logic [CELL_W-1:0] div_quo;
  logic [CNT_W-1:0]  div_cnt;
  logic [UC_W:0]     div_trial;
  logic              div_bit;
  logic [UC_W-1:0]   rem_next;
  logic [CELL_W-1:0] quo_next;

  // sweep counter
  logic [CELL_W-1:0] clr_cnt;

  // neighbor words captured from the cell memory
  logic [4:0] cur_word;
  logic [4:0] up_word;
  logic [4:0] rt_word;
  logic [4:0] dn_word;
  logic [CELL_W-1:0] nxt_addr;
  logic [4:0]        nxt_word;

  // cell memory: bit 4 visited, bits 3:0 walls
  logic [4:0]        cell_mem [CELL_COUNT];
  logic [CELL_W-1:0] ra_addr;
  logic [CELL_W-1:0] rb_addr;
  logic [4:0]        rd_a;
  logic [4:0]        rd_b;
  logic              cm_we;
  logic [CELL_W-1:0] cm_waddr;
  logic [4:0]        cm_wdata;

  // stack memory
  logic [CELL_W-1:0] stk_mem [CELL_COUNT];
  logic              stk_we;
  logic [CELL_W-1:0] stk_rdata;

  // grid geometry
  logic [UC_W-1:0]  ucols;
  logic [UR_W-1:0]  urows;
  logic [TOT_W-1:0] total;
  logic             in_grid;
  logic             ex_up, ex_rt, ex_dn, ex_lf;
  logic [CELL_W-1:0] up_a, rt_a, dn_a, lf_a;

  // pick logic
  logic [3:0]        cand;
  logic [2:0]        cand_cnt;
  logic [1:0]        pick;
  logic [1:0]        dir;
  logic [CELL_W-1:0] pick_addr;
  logic [4:0]        pick_word;
  logic [3:0]        cur_walls_new;
  logic              accept;
  logic              res_free;

  // clamp the register values to the supported grid
  always_comb begin
    if (grid_columns == '0) begin
      ucols = UC_W'(1);
    end else if (32'(grid_columns) > MAX_COLUMNS) begin
      ucols = UC_W'(MAX_COLUMNS);
    end else begin
      ucols = UC_W'(grid_columns);
    end
    if (grid_rows == '0) begin
      urows = UR_W'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      urows = UR_W'(MAX_ROWS);
    end else begin
      urows = UR_W'(grid_rows);
    end
    total = TOT_W'(ucols) * TOT_W'(urows);
  end

  // neighbor presence and addresses around the walker
  assign in_grid = 32'(row) < 32'(urows);
  assign ex_up   = in_grid && (row != '0);
  assign ex_rt   = in_grid && (32'(col) + 1 < 32'(ucols));
  assign ex_dn   = in_grid && (32'(row) + 1 < 32'(urows));
  assign ex_lf   = in_grid && (col != '0);
  assign up_a    = ex_up ? walker - CELL_W'(ucols) : walker;
  assign rt_a    = ex_rt ? walker + CELL_W'(1) : walker;
  assign dn_a    = ex_dn ? walker + CELL_W'(ucols) : walker;
  assign lf_a    = ex_lf ? walker - CELL_W'(1) : walker;

  // read port addressing per state
  always_comb begin
    case (state)
      S_RD1: begin
        ra_addr = rt_a;
        rb_addr = dn_a;
      end
      S_RD2: begin
        ra_addr = lf_a;
        rb_addr = walker;
      end
      S_RDC: begin
        ra_addr = CELL_W'(cell_q);
        rb_addr = walker;
      end
      default: begin
        ra_addr = walker;
        rb_addr = up_a;
      end
    endcase
  end

  // choose among the unvisited neighbors
  always_comb begin
    cand     = {ex_lf & ~rd_a[4], ex_dn & ~dn_word[4], ex_rt & ~rt_word[4], ex_up & ~up_word[4]};
    cand_cnt = 3'($countones(cand));
    case (cand_cnt)
      3'd2:    pick = {1'b0, rnd_q[0]};
      3'd3:    pick = mod3_16(rnd_q);
      3'd4:    pick = rnd_q[1:0];
      default: pick = 2'd0;
    endcase
    dir = nth_set(cand, pick);
    case (dir)
      DIR_UP: begin
        pick_addr = up_a;
        pick_word = up_word;
      end
      DIR_RIGHT: begin
        pick_addr = rt_a;
        pick_word = rt_word;
      end
      DIR_DOWN: begin
        pick_addr = dn_a;
        pick_word = dn_word;
      end
      default: begin
        pick_addr = lf_a;
        pick_word = rd_a;
      end
    endcase
    if (cand_cnt != '0) begin
      cur_walls_new = cur_word[3:0] & ~(4'b0001 << dir);
    end else begin
      cur_walls_new = cur_word[3:0];
    end
  end

  // divider step: one quotient bit per cycle
  always_comb begin
    div_trial = {div_rem, div_quo[CELL_W-1]};
    div_bit   = div_trial >= {1'b0, ucols};
    if (div_bit) begin
      rem_next = UC_W'(div_trial - {1'b0, ucols});
    end else begin
      rem_next = UC_W'(div_trial);
    end
    quo_next = {div_quo[CELL_W-2:0], div_bit};
  end

  // cell memory write port
  always_comb begin
    case (state)
      S_CLEAR: begin
        cm_we    = 1'b1;
        cm_waddr = clr_cnt;
        cm_wdata = {1'b0, ALL_WALLS};
      end
      S_PICK: begin
        cm_we    = in_grid;
        cm_waddr = walker;
        cm_wdata = {1'b1, cur_walls_new};
      end
      S_DONE: begin
        cm_we    = carved_q;
        cm_waddr = nxt_addr;
        cm_wdata = nxt_word;
      end
      default: begin
        cm_we    = 1'b0;
        cm_waddr = walker;
        cm_wdata = cur_word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cell_mem[cm_waddr] <= cm_wdata;
    end
    rd_a <= cell_mem[ra_addr];
    rd_b <= cell_mem[rb_addr];
  end

  // stack memory: push at sp, the top entry is always on the read port
  assign sp_dec = sp - SP_W'(1);
  assign stk_we = (state == S_PICK) && (cand_cnt != '0) && (32'(sp) < CELL_COUNT);

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[sp[CELL_W-1:0]] <= walker;
    end
    stk_rdata <= stk_mem[sp_dec[CELL_W-1:0]];
  end

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;

  // control sequencer and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      grid_columns <= GRID_COLUMNS_RST;
      grid_rows    <= GRID_ROWS_RST;
      walker       <= '0;
      col          <= '0;
      row          <= '0;
      coord_valid  <= 1'b1;
      sp           <= '0;
      clr_cnt      <= '0;
      clr_item     <= 1'b0;
      res_valid    <= 1'b0;
      div_cnt      <= '0;
      carved_q     <= 1'b0;
    end else begin
      // drop a result once taken
      if (!res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CELL_W'(1);
          if (clr_cnt == CELL_W'(CELL_COUNT - 1)) begin
            state <= clr_item ? S_DONE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            cell_q   <= cell_index;
            rnd_q    <= random_value;
            read_ok  <= 32'(cell_index) < 32'(total);
            carved_q <= 1'b0;
            dir_q    <= DIR_UP;
            back_q   <= 1'b0;
            done_q   <= 1'b0;
            walls_q  <= '0;
            case (opcode)
              OP_STEP: begin
                if (coord_valid) begin
                  state <= S_RD1;
                end else begin
                  div_rem <= '0;
                  div_quo <= walker;
                  div_cnt <= CNT_W'(CELL_W);
                  state   <= S_DIV;
                end
              end
              OP_RESTART: begin
                walker      <= '0;
                col         <= '0;
                row         <= '0;
                if (!cfg_we) begin
                  coord_valid <= 1'b1;
                end
                sp          <= '0;
                clr_cnt     <= '0;
                clr_item    <= 1'b1;
                state       <= S_CLEAR;
              end
              OP_READ: begin
                state <= S_RDC;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        // rebuild row and column of the walker
        S_DIV: begin
          div_rem <= rem_next;
          div_quo <= quo_next;
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_cnt == CNT_W'(1)) begin
            row         <= quo_next;
            col         <= COL_W'(rem_next);
            if (!cfg_we) begin
              coord_valid <= 1'b1;
            end
            state       <= S_RD0;
          end
        end

        S_RD0: begin
          state <= S_RD1;
        end

        S_RD1: begin
          cur_word <= rd_a;
          up_word  <= rd_b;
          state    <= S_RD2;
        end

        S_RD2: begin
          rt_word <= rd_a;
          dn_word <= rd_b;
          state   <= S_PICK;
        end

        // advance to a neighbor, else pop the stack, else finish
        S_PICK: begin
          if (cand_cnt != '0) begin
            carved_q <= 1'b1;
            dir_q    <= dir;
            nxt_addr <= pick_addr;
            nxt_word <= {1'b1, pick_word[3:0] & ~(4'b0001 << (dir ^ 2'b10))};
            walker   <= pick_addr;
            case (dir)
              DIR_UP:    row <= row - ROW_W'(1);
              DIR_RIGHT: col <= col + COL_W'(1);
              DIR_DOWN:  row <= row + ROW_W'(1);
              default:   col <= col - COL_W'(1);
            endcase
            if (32'(sp) < CELL_COUNT) begin
              sp <= sp + SP_W'(1);
            end
          end else if (sp != '0) begin
            sp          <= sp_dec;
            walker      <= stk_rdata;
            if (!cfg_we) begin
              coord_valid <= 1'b0;
            end
            back_q      <= 1'b1;
          end else begin
            done_q <= 1'b1;
          end
          state <= S_DONE;
        end

        S_RDC: begin
          state <= S_RDW;
        end

        S_RDW: begin
          walls_q <= read_ok ? rd_a[3:0] : 4'h0;
          state   <= S_DONE;
        end

        // load the result register when it is free
        S_DONE: begin
          if (res_free) begin
            res_valid       <= 1'b1;
            current_cell    <= 7'(walker);
            carved          <= carved_q;
            carve_direction <= dir_q;
            backtracked     <= back_q;
            finished        <= done_q;
            stack_depth     <= 8'(sp);
            cell_walls      <= walls_q;
            carved_q        <= 1'b0;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // configuration writes; the walker's coordinates must be rebuilt
      if (cfg_we) begin
        coord_valid <= 1'b0;
        if (cfg_index == REG_COLUMNS) begin
          grid_columns <= cfg_data;
        end else begin
          grid_rows <= cfg_data[3:0];
        end
      end
    end
  end

endmodule

/* rtl/core/mbs_checker.sv */
// Port-level checks for the maze backtracker step block, bound to the top level.
module mbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [6:0] current_cell,
  input logic       carved,
  input logic [1:0] carve_direction,
  input logic       backtracked,
  input logic       finished,
  input logic [7:0] stack_depth,
  input logic [3:0] cell_walls
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(current_cell) && $stable(stack_depth)
      && $stable(cell_walls) && $stable(carved) && $stable(carve_direction))
    else $error("stalled result changed");

  // a result reports at most one of carve, backtrack or finish
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(carved && backtracked) && !(carved && finished)
      && !(backtracked && finished))
    else $error("more than one step outcome");

  // finishing only with an empty stack, carving always leaves at least one entry
  a_depth: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!finished || stack_depth == 8'd0) && (!carved || stack_depth != 8'd0))
    else $error("stack depth inconsistent with outcome");

  // no direction without a carve
  a_dir_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && !carved |-> carve_direction == 2'd0)
    else $error("direction reported without a carve");

  // the clearing pass after reset takes no request
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> req_stall)
    else $error("request taken during clearing pass");

endmodule

bind maze_backtracker_step mbs_checker u_mbs_checker (.*);
